// ===== sv/lef_pkg.sv =====
package lef_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int CNT_W        = 10;
    localparam int DIM_W        = 11;
    localparam int PIX_W        = 8;
    localparam int EDGE_W       = 10;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = DIM_W;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);
    localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(HEIGHT_LIMIT);
    localparam logic [EDGE_W-1:0] EDGE_MAX    = EDGE_W'(1020);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_index_t;

    typedef logic [PIX_W-1:0] pixel_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_MIN) r = DIM_MIN;
        if (v > hi) r = hi;
        return r;
    endfunction

endpackage

// ===== sv/laplacian_edge_filter_core.sv =====
// two register stages: stage a, then the result register, which takes a result when stage a moves on
// throughput: one pixel per cycle while no result is blocked, each line store takes one read and one write per pixel
// a pixel on a border centre passes through the stores and gives no result
// reset (aresetn low, synchronous): counters, window, fill count and valids clear,
// width and height return to 640 and 480; line stores are not swept, the fill count
// makes columns not yet written read as zero
module laplacian_edge_filter_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lef_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lef_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [lef_pkg::PIX_W-1:0]        s_pixel_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [lef_pkg::EDGE_W-1:0]       m_edge_value,
    output logic [lef_pkg::CNT_W-1:0]        m_out_row,
    output logic [lef_pkg::CNT_W-1:0]        m_out_col,
    output logic                             m_frame_last
);
    import lef_pkg::*;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] w_use, h_use;

    logic [CNT_W-1:0] col_reg, row_reg, col_next, row_next;
    logic [DIM_W-1:0] col_plus, row_plus;
    logic [DIM_W-1:0] fill_reg;

    pixel_t upper_mem [MAX_WIDTH];
    pixel_t middle_mem [MAX_WIDTH];
    pixel_t upper_rd_reg, middle_rd_reg;

    logic             a_valid_reg;
    pixel_t           a_pix_reg;
    logic [CNT_W-1:0] a_col_reg, a_row_reg;
    logic             a_hit_reg;

    pixel_t win_reg [6];

    logic              m_valid_reg;
    logic [EDGE_W-1:0] m_edge_reg;
    logic [CNT_W-1:0]  m_row_reg, m_col_reg;
    logic              m_last_reg;

    logic             s_accept, a_adv, a_prod, out_free;
    pixel_t           u_eff, m_eff;
    logic [EDGE_W-1:0] pos_sum, neg_sum, edge_val;
    logic             last_val;

    assign w_use = clamp_dim(width_reg, WIDTH_MAX);
    assign h_use = clamp_dim(height_reg, HEIGHT_MAX);

    // column and row counters with per-frame wrap
    always_comb begin
        col_plus = {1'b0, col_reg} + DIM_W'(1);
        row_plus = {1'b0, row_reg} + DIM_W'(1);
        col_next = col_plus[CNT_W-1:0];
        row_next = row_reg;
        if (col_plus >= w_use) begin
            col_next = '0;
            row_next = (row_plus >= h_use) ? '0 : row_plus[CNT_W-1:0];
        end
    end

    // stage a holds one pixel with its store reads; it moves on unless its result is blocked
    assign out_free = !m_valid_reg || m_ready;
    assign a_prod   = (a_row_reg >= CNT_W'(2)) && (a_col_reg >= CNT_W'(2));
    assign a_adv    = a_valid_reg && (!a_prod || out_free);
    assign s_ready  = !a_valid_reg || a_adv;
    assign s_accept = s_valid && s_ready;

    // columns at or past the fill count were never written and read as zero
    assign u_eff = a_hit_reg ? upper_rd_reg : '0;
    assign m_eff = a_hit_reg ? middle_rd_reg : '0;

    always_comb begin
        pos_sum = EDGE_W'(win_reg[3]) + EDGE_W'(win_reg[5])
                + EDGE_W'(win_reg[1]) + EDGE_W'(m_eff);
        neg_sum = {win_reg[4], 2'b00};
        edge_val = (pos_sum > neg_sum) ? (pos_sum - neg_sum) : '0;
        last_val = ({1'b0, a_row_reg} == (h_use - DIM_W'(1)))
                && ({1'b0, a_col_reg} == (w_use - DIM_W'(1)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            fill_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    width_reg <= cfg_data;
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                CFG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_data;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default: ;
            endcase
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (col_plus > fill_reg) fill_reg <= col_plus;
        end
    end

    // line stores: read and middle write on accept, upper write when stage a moves on
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            upper_rd_reg          <= upper_mem[col_reg[ADDR_W-1:0]];
            middle_rd_reg         <= middle_mem[col_reg[ADDR_W-1:0]];
            middle_mem[col_reg[ADDR_W-1:0]] <= s_pixel_value;
        end
        if (a_adv) begin
            upper_mem[a_col_reg[ADDR_W-1:0]] <= m_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_adv) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_pix_reg <= s_pixel_value;
            a_col_reg <= col_reg;
            a_row_reg <= row_reg;
            a_hit_reg <= ({1'b0, col_reg} < fill_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end else if (a_adv) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= u_eff;
            win_reg[4] <= m_eff;
            win_reg[5] <= a_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_adv && a_prod) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv && a_prod) begin
            m_edge_reg <= edge_val;
            m_row_reg  <= a_row_reg - CNT_W'(1);
            m_col_reg  <= a_col_reg - CNT_W'(1);
            m_last_reg <= last_val;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_edge_value = m_edge_reg;
    assign m_out_row    = m_row_reg;
    assign m_out_col    = m_col_reg;
    assign m_frame_last = m_last_reg;

endmodule

// ===== sv/lef_checker.sv =====
module lef_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [lef_pkg::PIX_W-1:0]        s_pixel_value,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [lef_pkg::EDGE_W-1:0]       m_edge_value,
    input logic [lef_pkg::CNT_W-1:0]        m_out_row,
    input logic [lef_pkg::CNT_W-1:0]        m_out_col,
    input logic                             m_frame_last
);
    import lef_pkg::*;

    // a waiting input item holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_pixel_value))
        else $error("input item changed while waiting");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_edge_value) && $stable(m_out_row)
            && $stable(m_out_col) && $stable(m_frame_last))
        else $error("result item changed while stalled");

    // input is only held off by a blocked result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a blocked result");

    a_edge_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_edge_value <= EDGE_MAX)
        else $error("edge value above largest response");

    // only interior centres come out
    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_row != '0 && m_out_col != '0)
        else $error("border pixel emitted");

endmodule

bind laplacian_edge_filter_core lef_checker u_lef_checker (.*);

// ===== bench/laplacian_edge_filter_core_tb.sv =====
`timescale 1ns / 1ps

module laplacian_edge_filter_core_tb;
    import lef_pkg::*;

    localparam int PIPE_DRAIN = 4;
    localparam int NUM_PHASES = 7;
    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum {ROW_PIXEL, ROW_WRITE} row_kind_t;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic [CNT_W-1:0]  out_row;
        logic [CNT_W-1:0]  out_col;
        logic              frame_last;
    } edge_result_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  idx;
        logic [DIM_W-1:0]        data;
        pixel_t                  pixel;
        bit                      typed;
        bit                      want;
        edge_result_t            res;
    } stim_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [PIX_W-1:0]        s_pixel_value;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [EDGE_W-1:0]       m_edge_value;
    logic [CNT_W-1:0]        m_out_row;
    logic [CNT_W-1:0]        m_out_col;
    logic                    m_frame_last;

    laplacian_edge_filter_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_edge_value  (m_edge_value),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_frame_last  (m_frame_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    int send_gap_pct;
    int recv_stall_pct;
    int errors = 0;

    edge_result_t expected_edges[$];
    stim_row_t    directed_rows[$];

    // filter state mirror
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    pixel_t           two_up_line [MAX_WIDTH];
    pixel_t           one_up_line [MAX_WIDTH];
    pixel_t           tap [6];
    int               cur_col;
    int               cur_row;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int dim_in_use(input logic [DIM_W-1:0] v, input int hi);
        int r;
        r = int'(v);
        if (r < 3) r = 3;
        if (r > hi) r = hi;
        return r;
    endfunction

    // one pixel through the 3x3 window; returns 1 when an interior centre completes
    function automatic bit filter_pixel(input pixel_t p, output edge_result_t res);
        int     w;
        int     h;
        int     sum;
        pixel_t u;
        pixel_t m;
        bit     hit;
        w = dim_in_use(width_reg, MAX_WIDTH);
        h = dim_in_use(height_reg, HEIGHT_LIMIT);
        u = two_up_line[cur_col];
        m = one_up_line[cur_col];
        hit = (cur_row >= 2) && (cur_col >= 2);
        res = '0;
        if (hit) begin
            // up + down + left + right - 4 * centre
            sum = int'(tap[3]) + int'(tap[5]) + int'(tap[1]) + int'(m) - 4 * int'(tap[4]);
            if (sum < 0) sum = 0;
            res.edge_value = sum[EDGE_W-1:0];
            res.out_row    = CNT_W'(cur_row - 1);
            res.out_col    = CNT_W'(cur_col - 1);
            res.frame_last = (cur_row == h - 1) && (cur_col == w - 1);
        end
        two_up_line[cur_col] = m;
        one_up_line[cur_col] = p;
        tap[0] = tap[3];
        tap[1] = tap[4];
        tap[2] = tap[5];
        tap[3] = u;
        tap[4] = m;
        tap[5] = p;
        cur_col++;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= h) cur_row = 0;
        end
        return hit;
    endfunction

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SEND: begin
                send_gap_pct = 80;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_gap_pct = 0;
                recv_stall_pct = 80;
            end
            IDLE_BOTH: begin
                send_gap_pct = 16;
                recv_stall_pct = 16;
            end
            default: begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // waits for the pipe to empty, then writes one register
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DIM_W-1:0] data);
        s_valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) begin
            width_reg = data;
            cur_col = 0;
            cur_row = 0;
        end else if (idx == CFG_IMAGE_HEIGHT) begin
            height_reg = data;
            cur_col = 0;
            cur_row = 0;
        end
    endtask

    // valid stays high across back-to-back items, dropped only for a gap
    task automatic push_pixel(input pixel_t p, output bit got, output edge_result_t res);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_value <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = filter_pixel(p, res);
    endtask

    task automatic add_write(input logic [CFG_INDEX_W-1:0] idx, input logic [DIM_W-1:0] data);
        stim_row_t r;
        r = '{ROW_WRITE, idx, data, 8'd0, 1'b0, 1'b0, '0};
        directed_rows.push_back(r);
    endtask

    task automatic add_pixel(input pixel_t p);
        stim_row_t r;
        r = '{ROW_PIXEL, 2'd0, 11'd0, p, 1'b0, 1'b0, '0};
        directed_rows.push_back(r);
    endtask

    task automatic add_typed(input pixel_t p, input bit want, input logic [EDGE_W-1:0] e,
                             input logic [CNT_W-1:0] r_row, input logic [CNT_W-1:0] r_col,
                             input logic last);
        stim_row_t r;
        r = '{ROW_PIXEL, 2'd0, 11'd0, p, 1'b1, want, '{e, r_row, r_col, last}};
        directed_rows.push_back(r);
    endtask

    always @(posedge aclk) begin : result_check
        edge_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_edges.size() == 0) begin
                $error("result with nothing pending: edge_value %0d out_row %0d out_col %0d",
                       m_edge_value, m_out_row, m_out_col);
                errors++;
            end else begin
                want = expected_edges.pop_front();
                if (m_edge_value !== want.edge_value) begin
                    $error("edge_value: expected %0d, got %0d", want.edge_value, m_edge_value);
                    errors++;
                end
                if (m_out_row !== want.out_row) begin
                    $error("out_row: expected %0d, got %0d", want.out_row, m_out_row);
                    errors++;
                end
                if (m_out_col !== want.out_col) begin
                    $error("out_col: expected %0d, got %0d", want.out_col, m_out_col);
                    errors++;
                end
                if (m_frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0d, got %0d", want.frame_last, m_frame_last);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t        row;
        edge_result_t     res;
        bit               got;
        logic [DIM_W-1:0] pw;
        logic [DIM_W-1:0] phh;
        int               n_items;
        idle_mode_t       mode;
        pixel_t           p;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_IMAGE_WIDTH;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_pixel_value = '0;
        width_reg     = WIDTH_RESET;
        height_reg    = HEIGHT_RESET;
        cur_col       = 0;
        cur_row       = 0;
        foreach (two_up_line[i]) begin
            two_up_line[i] = '0;
            one_up_line[i] = '0;
        end
        foreach (tap[i]) tap[i] = '0;
        set_idle(IDLE_NONE);

        // after reset the first row is all border
        add_typed(8'd255, 1'b0, '0, '0, '0, 1'b0);
        add_typed(8'd0, 1'b0, '0, '0, '0, 1'b0);
        // too small: both saturate to 3, the write also restarts the frame
        add_write(CFG_IMAGE_WIDTH, 11'd0);
        add_write(CFG_IMAGE_HEIGHT, 11'd2);
        // bright cross around a dark centre gives the top response
        add_typed(8'd0, 1'b0, '0, '0, '0, 1'b0);
        add_typed(8'd255, 1'b0, '0, '0, '0, 1'b0);
        add_typed(8'd0, 1'b0, '0, '0, '0, 1'b0);
        add_typed(8'd255, 1'b0, '0, '0, '0, 1'b0);
        add_typed(8'd0, 1'b0, '0, '0, '0, 1'b0);
        add_typed(8'd255, 1'b0, '0, '0, '0, 1'b0);
        add_typed(8'd0, 1'b0, '0, '0, '0, 1'b0);
        add_typed(8'd255, 1'b0, '0, '0, '0, 1'b0);
        add_typed(8'd0, 1'b1, 10'd1020, 10'd1, 10'd1, 1'b1);
        // bright centre clamps to zero; a spare-index write mid frame must not restart it
        add_pixel(8'd10);
        add_pixel(8'd200);
        add_pixel(8'd30);
        add_pixel(8'd40);
        add_write(CFG_SPARE_HI, 11'd2047);
        add_pixel(8'd250);
        add_pixel(8'd60);
        add_pixel(8'd70);
        add_pixel(8'd80);
        add_pixel(8'd90);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.idx, row.data);
            end else begin
                push_pixel(row.pixel, got, res);
                if (row.typed) begin
                    if (row.want) expected_edges.push_back(row.res);
                end else if (got) begin
                    expected_edges.push_back(res);
                end
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    pw = 11'd3; phh = 11'd3; n_items = 60; mode = IDLE_NONE;
                end
                1: begin
                    pw = 11'd7; phh = 11'd5; n_items = 80; mode = IDLE_SEND;
                end
                2: begin
                    pw = 11'd16; phh = 11'd6; n_items = 100; mode = IDLE_RECV;
                end
                3: begin
                    pw = 11'd5; phh = 11'd9; n_items = 80; mode = IDLE_BOTH;
                end
                4: begin
                    pw = DIM_W'($urandom_range(12, 3));
                    phh = DIM_W'($urandom_range(8, 3));
                    n_items = 80;
                    mode = IDLE_BOTH;
                end
                // narrowest width, height past the limit saturates
                5: begin
                    pw = 11'd2; phh = 11'd1025; n_items = 60; mode = IDLE_NONE;
                end
                // width past the limit saturates, start of the first row only
                default: begin
                    pw = 11'd1500; phh = 11'd0; n_items = 100; mode = IDLE_RECV;
                end
            endcase
            set_idle(mode);
            write_reg(CFG_IMAGE_WIDTH, pw);
            write_reg(CFG_IMAGE_HEIGHT, phh);
            if (ph == 4) write_reg(CFG_SPARE_LO, DIM_W'($urandom_range(2047)));
            repeat (n_items) begin
                case ($urandom_range(7))
                    0: p = 8'd0;
                    1: p = 8'd255;
                    default: p = PIX_W'($urandom_range(255));
                endcase
                push_pixel(p, got, res);
                if (got) expected_edges.push_back(res);
            end
        end

        s_valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge aclk);
        repeat (4 * PIPE_DRAIN) @(posedge aclk);
        if (errors == 0 && expected_edges.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
